[sv/fdr_pkg.sv]
// Shared types and constants for the Fresnel dielectric reflectance pipeline.
// Has no dependencies; every other file refers to it by scoped names.
package fdr_pkg;

    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 21;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // Fields that ride alongside the square root.
    typedef struct packed {
        logic [15:0] eta;
        logic [15:0] c;
        logic [30:0] ec;
        logic        tir;
    } side_t;

    // State of the digit-by-digit square root.
    typedef struct packed {
        logic [54:0] v;
        logic [55:0] r;
        side_t       side;
    } sqrt_t;

    // State of the two restoring dividers (s and p lanes).
    typedef struct packed {
        logic [32:0] s_rem;
        logic [31:0] s_den;
        logic [20:0] s_q;
        logic [45:0] p_rem;
        logic [44:0] p_den;
        logic [20:0] p_q;
        logic        tir;
        logic        zero;
    } div_t;

endpackage

[sv/fdr_sqrt_step.sv]
// One registered step of the integer square root (one result bit per step).
// Depends on fdr_pkg.
module fdr_sqrt_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [54:0]        bit_val,
    input  logic               in_valid,
    input  fdr_pkg::sqrt_t     in_data,
    output logic               out_valid,
    output fdr_pkg::sqrt_t     out_data
);

    logic           valid_reg;
    fdr_pkg::sqrt_t data_reg;
    fdr_pkg::sqrt_t data_next;
    logic [56:0]    trial;

    always_comb
    begin
        trial     = 57'(in_data.r) + 57'(bit_val);
        data_next = in_data;
        if (57'(in_data.v) >= trial)
        begin
            data_next.v = in_data.v - trial[54:0];
            data_next.r = (in_data.r >> 1) + 56'(bit_val);
        end
        else
        begin
            data_next.r = in_data.r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/fdr_div_step.sv]
// One registered step of the two restoring dividers, one quotient bit per lane.
// Depends on fdr_pkg.
module fdr_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fdr_pkg::div_t     in_data,
    output logic              out_valid,
    output fdr_pkg::div_t     out_data
);

    logic          valid_reg;
    fdr_pkg::div_t data_reg;
    fdr_pkg::div_t data_next;
    logic          s_bit;
    logic          p_bit;
    logic [32:0]   s_left;
    logic [45:0]   p_left;

    always_comb
    begin
        s_bit  = in_data.s_rem >= {1'b0, in_data.s_den};
        p_bit  = in_data.p_rem >= {1'b0, in_data.p_den};
        s_left = s_bit ? (in_data.s_rem - {1'b0, in_data.s_den}) : in_data.s_rem;
        p_left = p_bit ? (in_data.p_rem - {1'b0, in_data.p_den}) : in_data.p_rem;
        data_next       = in_data;
        data_next.s_rem = {s_left[31:0], 1'b0};
        data_next.p_rem = {p_left[44:0], 1'b0};
        data_next.s_q   = {in_data.s_q[19:0], s_bit};
        data_next.p_q   = {in_data.p_q[19:0], p_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/fresnel_dielectric_reflectance_core.sv]
// Top level of the Fresnel dielectric reflectance pipeline.
// Depends on fdr_pkg, fdr_sqrt_step and fdr_div_step.
//
// Usage: a request on the slave stream carries eta_ratio (Q4.12) in s_tdata[15:0]
// and cos_incident (Q1.15) in s_tdata[31:16]. Each request yields one result on the
// master stream: the unpolarized reflectance (Q1.15, at most 1.0) in m_tdata and
// the total internal reflection flag in m_tuser.
// From acceptance to m_tvalid a request passes three front stages for the
// products and the total internal reflection test, 28 square root steps, two
// stages that form the numerators and denominators, 21 divider steps, a squaring
// stage and the output register. A request is accepted every cycle unless stalled.
// The whole pipeline advances together; when the receiver holds m_tready low
// with a result waiting, every stage holds and s_tready drops, so nothing is lost
// or repeated. s_tready stays high while the output register is empty.
// Reset clears all valid bits; the datapath registers are not reset.
// A cosine above 1.0 is clamped to 1.0, and a zero denominator yields 1.0.
module fresnel_dielectric_reflectance_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] eta_ratio, [31:16] cos_incident
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] reflectance
    output logic        m_tuser    // [0] total_internal
);

    logic en;

    // Front stage 1: clamp the cosine and form the first products.
    logic        v1_reg;
    logic [15:0] eta1_reg;
    logic [15:0] c1_reg;
    logic [30:0] ec1_reg;
    logic [30:0] cc1_reg;
    logic [31:0] ee1_reg;
    logic [15:0] c_sat;

    // Front stage 2: sin^2 times eta^2.
    logic        v2_reg;
    logic [15:0] eta2_reg;
    logic [15:0] c2_reg;
    logic [30:0] ec2_reg;
    logic [62:0] k2_reg;

    // Front stage 3: total internal reflection test and square root seed.
    logic           v3_reg;
    fdr_pkg::sqrt_t sq3_reg;
    fdr_pkg::sqrt_t sq3_next;

    logic           sq_valid [fdr_pkg::SQRT_STEPS+1];
    fdr_pkg::sqrt_t sq_data  [fdr_pkg::SQRT_STEPS+1];

    // Post stage 1: eta times the transmitted cosine, s lane operands.
    logic        vp1_reg;
    logic [43:0] ept1_reg;
    logic [27:0] t01_reg;
    logic [30:0] ecp1_reg;
    logic [15:0] cp1_reg;
    logic        tirp1_reg;

    // Post stage 2: numerators and denominators, divider seed.
    logic          vp2_reg;
    fdr_pkg::div_t dv2_reg;
    fdr_pkg::div_t dv2_next;

    logic          dv_valid [fdr_pkg::DIV_STEPS+1];
    fdr_pkg::div_t dv_data  [fdr_pkg::DIV_STEPS+1];

    // Squaring stage.
    logic        vq_reg;
    logic [41:0] rs2_reg;
    logic [41:0] rp2_reg;
    logic        tirq_reg;
    logic        zeroq_reg;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] refl_reg;
    logic        tir_out_reg;
    logic [15:0] refl_next;
    logic [42:0] sq_sum;
    logic [41:0] mean;
    logic [41:0] rounded;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign c_sat = (s_tdata[31:16] > fdr_pkg::ONE_Q15) ? fdr_pkg::ONE_Q15 : s_tdata[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vp1_reg       <= 1'b0;
            vp2_reg       <= 1'b0;
            vq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vp1_reg       <= sq_valid[fdr_pkg::SQRT_STEPS];
            vp2_reg       <= vp1_reg;
            vq_reg        <= dv_valid[fdr_pkg::DIV_STEPS];
            out_valid_reg <= vq_reg;
        end
    end

    always_comb
    begin
        sq3_next.side.eta = eta2_reg;
        sq3_next.side.c   = c2_reg;
        sq3_next.side.ec  = ec2_reg;
        sq3_next.side.tir = k2_reg > (63'd1 << 54);
        sq3_next.r        = '0;
        sq3_next.v        = sq3_next.side.tir ? '0 : 55'((63'd1 << 54) - k2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eta1_reg <= s_tdata[15:0];
            c1_reg   <= c_sat;
            ec1_reg  <= 31'(s_tdata[15:0]) * 31'(c_sat);
            cc1_reg  <= 31'(c_sat) * 31'(c_sat);
            ee1_reg  <= s_tdata[15:0] * s_tdata[15:0];

            eta2_reg <= eta1_reg;
            c2_reg   <= c1_reg;
            ec2_reg  <= ec1_reg;
            k2_reg   <= 63'(31'h4000_0000 - cc1_reg) * 63'(ee1_reg);

            sq3_reg  <= sq3_next;
        end
    end

    assign sq_valid[0] = v3_reg;
    assign sq_data[0]  = sq3_reg;

    for (genvar i = 0; i < fdr_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        fdr_sqrt_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .bit_val   (55'd1 << (54 - 2 * i)),
            .in_valid  (sq_valid[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t01_reg   <= sq_data[fdr_pkg::SQRT_STEPS].r[27:0];
            ept1_reg  <= sq_data[fdr_pkg::SQRT_STEPS].side.eta
                         * sq_data[fdr_pkg::SQRT_STEPS].r[27:0];
            ecp1_reg  <= sq_data[fdr_pkg::SQRT_STEPS].side.ec;
            cp1_reg   <= sq_data[fdr_pkg::SQRT_STEPS].side.c;
            tirp1_reg <= sq_data[fdr_pkg::SQRT_STEPS].side.tir;
        end
    end

    always_comb
    begin
        logic [31:0] s_a;
        logic [31:0] s_b;
        logic [44:0] p_a;
        logic [44:0] p_b;
        s_a = 32'(ecp1_reg);
        s_b = 32'(t01_reg);
        p_a = 45'(ept1_reg);
        p_b = 45'(cp1_reg) << 24;
        dv2_next.s_den = s_a + s_b;
        dv2_next.s_rem = 33'((s_a >= s_b) ? (s_a - s_b) : (s_b - s_a));
        dv2_next.p_den = p_a + p_b;
        dv2_next.p_rem = 46'((p_a >= p_b) ? (p_a - p_b) : (p_b - p_a));
        dv2_next.s_q   = '0;
        dv2_next.p_q   = '0;
        dv2_next.tir   = tirp1_reg;
        dv2_next.zero  = (dv2_next.s_den == '0) || (dv2_next.p_den == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv2_reg <= dv2_next;
    end

    assign dv_valid[0] = vp2_reg;
    assign dv_data[0]  = dv2_reg;

    for (genvar j = 0; j < fdr_pkg::DIV_STEPS; j++)
    begin : g_div
        fdr_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[j]),
            .in_data   (dv_data[j]),
            .out_valid (dv_valid[j+1]),
            .out_data  (dv_data[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs2_reg   <= dv_data[fdr_pkg::DIV_STEPS].s_q * dv_data[fdr_pkg::DIV_STEPS].s_q;
            rp2_reg   <= dv_data[fdr_pkg::DIV_STEPS].p_q * dv_data[fdr_pkg::DIV_STEPS].p_q;
            tirq_reg  <= dv_data[fdr_pkg::DIV_STEPS].tir;
            zeroq_reg <= dv_data[fdr_pkg::DIV_STEPS].zero;
        end
    end

    // Mean of the squared ratios, rounded half up from Q.40 to Q.15, then clamped.
    always_comb
    begin
        sq_sum  = 43'(rs2_reg) + 43'(rp2_reg);
        mean    = sq_sum[42:1];
        rounded = (mean + (42'd1 << 24)) >> 25;
        if (tirq_reg || zeroq_reg || rounded > 42'(fdr_pkg::ONE_Q15))
            refl_next = fdr_pkg::ONE_Q15;
        else
            refl_next = rounded[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            refl_reg    <= refl_next;
            tir_out_reg <= tirq_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = refl_reg;
    assign m_tuser  = tir_out_reg;

`ifndef ASSERT_OFF
    a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == fdr_pkg::ONE_Q15))
        else $error("total internal reflection without full reflectance");

    a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= fdr_pkg::ONE_Q15))
        else $error("reflectance above 1.0");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output register");
`endif

endmodule
